>>> hdl/buddy_allocator_alloc_unit_macros.svh
// Assertion macros for the buddy allocator allocation unit.
`ifndef BUDDY_ALLOCATOR_ALLOC_UNIT_MACROS_SVH
`define BUDDY_ALLOCATOR_ALLOC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BDA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocation unit assertion failed");
`define BDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocation unit assertion failed");
`else
`define BDA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BDA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/bda_pkg.sv
// Shared types and constants of the buddy allocator allocation unit.
`default_nettype none
package bda_pkg;
   localparam int SMALLEST_ORDER_DEF = 5;
   localparam int POOL_ORDER_DEF     = 20;
   localparam int HEADER_BYTES_DEF   = 16;

   localparam int REQ_W       = 32;
   localparam int NEED_W      = 33;
   localparam int ORD_W       = 6;
   localparam int ST_W        = 2;
   localparam int BLK_W       = 20;
   localparam int PAY_W       = 21;
   localparam int BORD_W      = 5;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [ST_W-1:0] {
      ST_GRANTED  = 2'd0,
      ST_TOO_BIG  = 2'd1,
      ST_NO_SPACE = 2'd2
   } bda_status_type;

   typedef struct packed {
      logic             too_big;
      logic [ORD_W-1:0] target;
   } bda_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } bda_qstat_type;

   typedef struct packed {
      logic              valid;
      logic [ST_W-1:0]   status;
      logic [BLK_W-1:0]  block_offset;
      logic [PAY_W-1:0]  payload_offset;
      logic [BORD_W-1:0] block_order;
   } bda_rsp_type;
endpackage
`default_nettype wire

>>> hdl/bda_front.sv
// Front end: takes a request and works out its target order, one order a cycle.
`default_nettype none
module bda_front #(
   parameter int SMALLEST_ORDER = bda_pkg::SMALLEST_ORDER_DEF,
   parameter int POOL_ORDER     = bda_pkg::POOL_ORDER_DEF,
   parameter int HEADER_BYTES   = bda_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [bda_pkg::REQ_W-1:0]   req_request_bytes,
   output logic                             busy,
   output logic                             push,
   output bda_pkg::bda_job_type             job,
   input  bda_pkg::bda_qstat_type           qstat
);
   localparam logic [bda_pkg::ORD_W-1:0] SmallOrd = bda_pkg::ORD_W'(SMALLEST_ORDER);
   localparam logic [bda_pkg::ORD_W-1:0] PoolOrd  = bda_pkg::ORD_W'(POOL_ORDER);

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_SCAN = 2'b10
   } bda_front_state_type;

   bda_front_state_type              state_ff, state_in;
   logic [bda_pkg::NEED_W-1:0]       need_ff, need_in;
   logic [bda_pkg::ORD_W-1:0]        tgt_ff, tgt_in;
   logic [bda_pkg::NEED_W:0]         pow;
   logic                             grow;

   always_comb begin
      pow  = {{bda_pkg::NEED_W{1'b0}}, 1'b1} << tgt_ff;
      grow = (tgt_ff <= PoolOrd) && (pow < {1'b0, need_ff});
   end

   always_comb begin
      state_in = state_ff;
      need_in  = need_ff;
      tgt_in   = tgt_ff;
      push     = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               need_in  = bda_pkg::NEED_W'(req_request_bytes)
                        + bda_pkg::NEED_W'(HEADER_BYTES);
               tgt_in   = SmallOrd;
               state_in = F_SCAN;
            end
         end
         F_SCAN: begin
            if (grow) begin
               tgt_in = tgt_ff + bda_pkg::ORD_W'(1);
            end else if (!qstat.full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign job.too_big = (tgt_ff > PoolOrd);
   assign job.target  = tgt_ff;
   assign busy        = (state_ff == F_SCAN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff <= need_in;
      tgt_ff  <= tgt_in;
   end
endmodule
`default_nettype wire

>>> hdl/bda_queue.sv
// Short job queue between the front end and the back end.
`default_nettype none
module bda_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  bda_pkg::bda_job_type    push_job,
   input  wire logic               pop,
   output bda_pkg::bda_job_type    head,
   output bda_pkg::bda_qstat_type  qstat
);
   localparam int PtrW = (bda_pkg::QUEUE_DEPTH > 1) ? $clog2(bda_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(bda_pkg::QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(bda_pkg::QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(bda_pkg::QUEUE_DEPTH);

   bda_pkg::bda_job_type  entry_ff [bda_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   assign head        = entry_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == FullCnt);
   assign qstat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end
endmodule
`default_nettype wire

>>> hdl/bda_back.sv
// Back end: free-order search, block take and buddy splitting, one order a cycle.
`default_nettype none
module bda_back #(
   parameter int POOL_ORDER   = bda_pkg::POOL_ORDER_DEF,
   parameter int HEADER_BYTES = bda_pkg::HEADER_BYTES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  bda_pkg::bda_qstat_type  qstat,
   input  bda_pkg::bda_job_type    head,
   output logic                    pop,
   output bda_pkg::bda_rsp_type    rsp
);
   localparam int OffW  = POOL_ORDER;
   localparam int SlotW = $clog2(POOL_ORDER + 1);
   localparam int MemAW = $clog2(POOL_ORDER);
   localparam int SumW  = ((POOL_ORDER > bda_pkg::PAY_W) ? POOL_ORDER : bda_pkg::PAY_W) + 1;
   localparam logic [bda_pkg::ORD_W-1:0] PoolOrd   = bda_pkg::ORD_W'(POOL_ORDER);
   localparam logic [POOL_ORDER:0]       FreeReset = {1'b1, {POOL_ORDER{1'b0}}};

   typedef enum logic [3:0] {
      B_IDLE   = 4'b0001,
      B_SEARCH = 4'b0010,
      B_FETCH  = 4'b0100,
      B_SPLIT  = 4'b1000
   } bda_back_state_type;

   bda_back_state_type          state_ff, state_in;
   logic [bda_pkg::ORD_W-1:0]   cur_ff, cur_in;
   logic [bda_pkg::ORD_W-1:0]   tgt_ff, tgt_in;
   logic [bda_pkg::ORD_W-1:0]   cur_dec;
   logic [OffW-1:0]             blk_ff, blk_in;
   logic [POOL_ORDER:0]         free_ff, free_in;
   logic [OffW-1:0]             mem [POOL_ORDER];
   logic [OffW-1:0]             rd_ff;
   logic                        mem_we;
   logic [MemAW-1:0]            mem_wa;
   logic [MemAW-1:0]            mem_ra;
   logic [OffW-1:0]             mem_wd;
   logic [SumW-1:0]             blk_wide;
   logic [SumW-1:0]             pay_wide;
   bda_pkg::bda_rsp_type        rsp_ff, rsp_in;

   always_comb begin
      cur_dec  = cur_ff - bda_pkg::ORD_W'(1);
      mem_ra   = cur_ff[MemAW-1:0];
      mem_wa   = cur_dec[MemAW-1:0];
      mem_wd   = blk_ff + (OffW'(1) << cur_dec);
      blk_wide = SumW'(blk_ff);
      pay_wide = blk_wide + SumW'(HEADER_BYTES);
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      blk_in       = blk_ff;
      free_in      = free_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      rsp_in       = rsp_ff;
      rsp_in.valid = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!qstat.empty) begin
               pop    = 1'b1;
               cur_in = head.target;
               tgt_in = head.target;
               if (head.too_big) begin
                  rsp_in.valid          = 1'b1;
                  rsp_in.status         = bda_pkg::ST_TOO_BIG;
                  rsp_in.block_offset   = '0;
                  rsp_in.payload_offset = '0;
                  rsp_in.block_order    = '0;
               end else begin
                  state_in = B_SEARCH;
               end
            end
         end
         B_SEARCH: begin
            if (cur_ff > PoolOrd) begin
               rsp_in.valid          = 1'b1;
               rsp_in.status         = bda_pkg::ST_NO_SPACE;
               rsp_in.block_offset   = '0;
               rsp_in.payload_offset = '0;
               rsp_in.block_order    = '0;
               state_in              = B_IDLE;
            end else if (free_ff[cur_ff[SlotW-1:0]]) begin
               free_in[cur_ff[SlotW-1:0]] = 1'b0;
               state_in                   = B_FETCH;
            end else begin
               cur_in = cur_ff + bda_pkg::ORD_W'(1);
            end
         end
         B_FETCH: begin
            // the top order's free block only ever sits at offset zero
            blk_in   = (cur_ff == PoolOrd) ? '0 : rd_ff;
            state_in = B_SPLIT;
         end
         B_SPLIT: begin
            if (cur_ff > tgt_ff) begin
               cur_in                      = cur_dec;
               free_in[cur_dec[SlotW-1:0]] = 1'b1;
               mem_we                      = 1'b1;
            end else begin
               rsp_in.valid          = 1'b1;
               rsp_in.status         = bda_pkg::ST_GRANTED;
               rsp_in.block_offset   = blk_wide[bda_pkg::BLK_W-1:0];
               rsp_in.payload_offset = pay_wide[bda_pkg::PAY_W-1:0];
               rsp_in.block_order    = tgt_ff[bda_pkg::BORD_W-1:0];
               state_in              = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         free_ff      <= FreeReset;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.status         <= rsp_in.status;
      rsp_ff.block_offset   <= rsp_in.block_offset;
      rsp_ff.payload_offset <= rsp_in.payload_offset;
      rsp_ff.block_order    <= rsp_in.block_order;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      tgt_ff <= tgt_in;
      blk_ff <= blk_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end
endmodule
`default_nettype wire

>>> hdl/buddy_allocator_alloc_unit.sv
// Top level of the buddy allocator allocation unit.
//
//   channel   ports                                      handshake
//   request   start, busy, req_request_bytes             taken when start && !busy
//   result    rsp_valid, rsp_status, rsp_block_offset,   one-cycle strobe, always taken
//             rsp_payload_offset, rsp_block_order
//
// Front end scans the target order one per cycle; back end searches and splits one order
// per cycle. A queued item first waits out the jobs ahead of it in the back end.
// Reset marks only the top order free; no clearing pass. Results cannot be held off;
// a two-item queue lets the front end take the next request while the back end works.
`default_nettype none
`include "buddy_allocator_alloc_unit_macros.svh"
module buddy_allocator_alloc_unit #(
   parameter int SMALLEST_ORDER = bda_pkg::SMALLEST_ORDER_DEF,
   parameter int POOL_ORDER     = bda_pkg::POOL_ORDER_DEF,
   parameter int HEADER_BYTES   = bda_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [bda_pkg::REQ_W-1:0]   req_request_bytes,
   output logic                             rsp_valid,
   output logic [bda_pkg::ST_W-1:0]         rsp_status,
   output logic [bda_pkg::BLK_W-1:0]        rsp_block_offset,
   output logic [bda_pkg::PAY_W-1:0]        rsp_payload_offset,
   output logic [bda_pkg::BORD_W-1:0]       rsp_block_order
);
   logic                     push;
   logic                     pop;
   bda_pkg::bda_job_type     push_job;
   bda_pkg::bda_job_type     head;
   bda_pkg::bda_qstat_type   qstat;
   bda_pkg::bda_rsp_type     rsp;
   logic [bda_pkg::BLK_W-1:0] align_mask;

   bda_front #(
      .SMALLEST_ORDER (SMALLEST_ORDER),
      .POOL_ORDER     (POOL_ORDER),
      .HEADER_BYTES   (HEADER_BYTES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_request_bytes (req_request_bytes),
      .busy              (busy),
      .push              (push),
      .job               (push_job),
      .qstat             (qstat)
   );

   bda_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   bda_back #(
      .POOL_ORDER   (POOL_ORDER),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .qstat (qstat),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

   assign rsp_valid          = rsp.valid;
   assign rsp_status         = rsp.status;
   assign rsp_block_offset   = rsp.block_offset;
   assign rsp_payload_offset = rsp.payload_offset;
   assign rsp_block_order    = rsp.block_order;

   assign align_mask = bda_pkg::BLK_W'((64'd1 << rsp_block_order) - 64'd1);

   `BDA_ASSERT_NEXT(a_busy_after_take, clock, reset, start && !busy, busy)
   `BDA_ASSERT_IMPL(a_reject_zeroed, clock, reset, rsp_valid && (rsp_status != bda_pkg::ST_GRANTED), (rsp_block_offset == '0) && (rsp_payload_offset == '0) && (rsp_block_order == '0))
   `BDA_ASSERT_IMPL(a_grant_aligned, clock, reset, rsp_valid && (rsp_status == bda_pkg::ST_GRANTED), (rsp_block_offset & align_mask) == '0)
endmodule
`default_nettype wire

>>> tb/sv/tb_buddy_allocator_alloc_unit.sv
// Self-checking testbench for the buddy allocator allocation unit.
`default_nettype none
module tb_buddy_allocator_alloc_unit;
   localparam int SMALLEST     = bda_pkg::SMALLEST_ORDER_DEF;
   localparam int POOL         = bda_pkg::POOL_ORDER_DEF;
   localparam int HDR          = bda_pkg::HEADER_BYTES_DEF;
   localparam int REQ_W        = bda_pkg::REQ_W;
   localparam int ST_W         = bda_pkg::ST_W;
   localparam int BLK_W        = bda_pkg::BLK_W;
   localparam int PAY_W        = bda_pkg::PAY_W;
   localparam int BORD_W       = bda_pkg::BORD_W;
   localparam int RANDOM_ITEMS = 1150;
   localparam int DRAIN_CYCLES = 2 * (POOL - SMALLEST) + 20;
   localparam int CYCLE_LIMIT  = 250000;

   typedef struct {
      bda_pkg::bda_status_type status;
      logic [BLK_W-1:0]        block_offset;
      logic [PAY_W-1:0]        payload_offset;
      logic [BORD_W-1:0]       block_order;
   } alloc_result_type;

   class alloc_scoreboard;
      bit               order_free [0:POOL];
      logic [BLK_W-1:0] free_base  [0:POOL];
      alloc_result_type due_results[$];
      int               errors;

      function new();
         foreach (order_free[o]) begin
            order_free[o] = 1'b0;
            free_base[o]  = '0;
         end
         order_free[POOL] = 1'b1;
         errors = 0;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      // Predict the result (grant, too big or no space) for an accepted item and queue it.
      function void note_request(logic [REQ_W-1:0] bytes);
         logic [63:0]      need;
         int               tgt;
         int               cur;
         logic [BLK_W-1:0] base;
         alloc_result_type res;
         need = 64'(bytes) + 64'(HDR);
         tgt  = SMALLEST;
         while (tgt <= POOL && (64'd1 << tgt) < need) tgt++;
         res.status         = bda_pkg::ST_TOO_BIG;
         res.block_offset   = '0;
         res.payload_offset = '0;
         res.block_order    = '0;
         if (tgt <= POOL) begin
            cur = tgt;
            while (cur <= POOL && !order_free[cur]) cur++;
            if (cur > POOL) begin
               res.status = bda_pkg::ST_NO_SPACE;
            end else begin
               base            = free_base[cur];
               order_free[cur] = 1'b0;
               free_base[cur]  = '0;
               // upper buddy of each split stays free
               while (cur > tgt) begin
                  cur--;
                  order_free[cur] = 1'b1;
                  free_base[cur]  = base + (BLK_W'(1) << cur);
               end
               res.status         = bda_pkg::ST_GRANTED;
               res.block_offset   = base;
               res.payload_offset = PAY_W'(base) + PAY_W'(HDR);
               res.block_order    = BORD_W'(tgt);
            end
         end
         due_results.push_back(res);
      endfunction

      task report(string msg);
         $display("%0t: allocation mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic [ST_W-1:0] st, logic [BLK_W-1:0] blk,
                        logic [PAY_W-1:0] pay, logic [BORD_W-1:0] ord);
         alloc_result_type due;
         if (due_results.size() == 0) begin
            report("result with no item outstanding");
            return;
         end
         due = due_results.pop_front();
         if (st !== due.status)
            report($sformatf("status %0d, expected %0d", st, due.status));
         if (blk !== due.block_offset)
            report($sformatf("block_offset %0h, expected %0h", blk, due.block_offset));
         if (pay !== due.payload_offset)
            report($sformatf("payload_offset %0h, expected %0h", pay, due.payload_offset));
         if (ord !== due.block_order)
            report($sformatf("block_order %0d, expected %0d", ord, due.block_order));
      endtask
   endclass

   logic              clock;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [REQ_W-1:0]  req_request_bytes = '0;
   logic              rsp_valid;
   logic [ST_W-1:0]   rsp_status;
   logic [BLK_W-1:0]  rsp_block_offset;
   logic [PAY_W-1:0]  rsp_payload_offset;
   logic [BORD_W-1:0] rsp_block_order;
   int                cycle_count = 0;

   alloc_scoreboard ledger = new();

   // deepest split first, then the half-pool grant, then the corner sizes
   logic [REQ_W-1:0] directed_sizes [18] = '{
      32'd0, 32'd16, 32'd17, 32'h0007_FFF0, 32'h0007_FFF1, 32'h000F_FFF0,
      32'h000F_FFF1, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h0003_FFF0, 32'd1,
      32'd15, 32'd48, 32'd49, 32'd1000, 32'd4080, 32'd4081, 32'h8000_0000
   };

   buddy_allocator_alloc_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_request_bytes  (req_request_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_block_offset   (rsp_block_offset),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_block_order    (rsp_block_order)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_buddy_allocator_alloc_unit: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         ledger.check_result(rsp_status, rsp_block_offset, rsp_payload_offset,
                             rsp_block_order);
   end

   task automatic send_request(input logic [REQ_W-1:0] bytes);
      start             <= 1'b1;
      req_request_bytes <= bytes;
      do @(posedge clock); while (busy);
      ledger.note_request(bytes);
   endtask

   task automatic idle_gap(input bit allow);
      if (allow) begin
         while ($urandom_range(99) < 37) begin
            start             <= 1'b0;
            req_request_bytes <= $urandom();
            @(posedge clock);
         end
      end
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [REQ_W-1:0] pick_request_size();
      int unsigned sel;
      int unsigned k;
      sel = $urandom_range(99);
      k   = $urandom_range(POOL, SMALLEST);
      if (sel < 55)
         return $urandom_range(1200, 0);
      else if (sel < 75)
         return $urandom_range(20000, 1201);
      else if (sel < 85)
         return $urandom_range(1 << POOL, 20001);
      else if (sel < 92)
         return (REQ_W'(1) << k) - REQ_W'(17) + $urandom_range(2, 0);
      else
         return $urandom();
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_sizes[n]) begin
         send_request(directed_sizes[n]);
         idle_gap(1'b1);
      end
      hold_until_drained();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_request(pick_request_size());
         idle_gap(!(i >= 300 && i < 500));
         if (i == 700)
            hold_until_drained();
      end
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("tb_buddy_allocator_alloc_unit: PASS");
      end else begin
         $display("tb_buddy_allocator_alloc_unit: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
